### rtl/lsp_pkg.sv
// lsp_pkg: shared sizes, codes and types for the slot pool
// no dependencies; used by lifetime_slot_pool
package lsp_pkg;

   localparam int MAX_SLOTS = 32;
   localparam int LIFE_BITS = 24;

   localparam int AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SLOT_W = 6;
   localparam int LIFE_W = 24;
   localparam int CAP_W  = 6;
   localparam int KIND_W = 3;
   localparam int FUNC_W = 2;
   localparam int CMP_W  = (LIFE_BITS > LIFE_W) ? LIFE_BITS : LIFE_W;

   localparam logic [FUNC_W-1:0] FUNC_SPAWN = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

   localparam logic [KIND_W-1:0] KIND_SPAWN   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RETIRED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

   typedef struct packed {
      logic [AW-1:0]        slot;
      logic [LIFE_BITS-1:0] life;
   } entry_type;

endpackage

### rtl/lsp_ram.sv
// lsp_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lsp_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lifetime_slot_pool.sv
// lifetime_slot_pool: slot pool with free stack, dense live list and slot map
// depends on lsp_pkg and lsp_ram
//
//   channel | ports                                   | handshake
//   req     | func, life_span, time_step, query_slot  | valid / stall
//   rsp     | kind, slot, ok, life_left, last         | valid / stall
//   csr     | wdata (capacity_in_use)                 | valid / ready
//
// spawn reads the free stack top (not when full), query the slot map then the live list
// (not for a slot not live), clear and tick each live entry; a tick moves the last entry
// into a retired entry's place unless it was last; each step is one ram read; rsp_stall
// holds the block in its output state; reset or a capacity write starts a fill of the
// free stack (MAX_SLOTS entries), during which req_stall is high
// a result waits in the output register while the next transaction is taken
module lifetime_slot_pool (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lsp_pkg::FUNC_W-1:0] req_func,
   input  logic [lsp_pkg::LIFE_W-1:0] req_life_span,
   input  logic [lsp_pkg::LIFE_W-1:0] req_time_step,
   input  logic [lsp_pkg::SLOT_W-1:0] req_query_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lsp_pkg::KIND_W-1:0] rsp_kind,
   output logic [lsp_pkg::SLOT_W-1:0] rsp_slot,
   output logic                       rsp_ok,
   output logic [lsp_pkg::LIFE_W-1:0] rsp_life_left,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lsp_pkg::CAP_W-1:0]  csr_wdata
);

   localparam int AW    = lsp_pkg::AW;
   localparam int CNT_W = lsp_pkg::CNT_W;
   localparam int LB    = lsp_pkg::LIFE_BITS;
   localparam int EW    = $bits(lsp_pkg::entry_type);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_SP_RD  = 4'd2;
   localparam logic [3:0] ST_TK_CHK = 4'd3;
   localparam logic [3:0] ST_TK_RD  = 4'd4;
   localparam logic [3:0] ST_TK_MV  = 4'd5;
   localparam logic [3:0] ST_CL_CHK = 4'd6;
   localparam logic [3:0] ST_CL_RD  = 4'd7;
   localparam logic [3:0] ST_Q_RD1  = 4'd8;
   localparam logic [3:0] ST_Q_RD2  = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0]                 state_ff, state_in, ret_ff, ret_in;
   logic [lsp_pkg::CAP_W-1:0]  cap_ff, cap_in, cap_sat;
   logic [CNT_W-1:0]           free_ff, free_in, lcnt_ff, lcnt_in;
   logic [CNT_W-1:0]           idx_ff, idx_in, cnt_ff, cnt_in, init_ff, init_in;
   logic [lsp_pkg::MAX_SLOTS-1:0] live_ff, live_in;
   logic [lsp_pkg::LIFE_W-1:0] step_ff, step_in;
   logic [LB-1:0]              span_ff, span_in;

   logic [lsp_pkg::KIND_W-1:0] pk_ff, pk_in;
   logic [lsp_pkg::SLOT_W-1:0] ps_ff, ps_in;
   logic                       pok_ff, pok_in, plast_ff, plast_in;
   logic [lsp_pkg::LIFE_W-1:0] pl_ff, pl_in;

   logic                       rv_ff, rv_in;
   logic [lsp_pkg::KIND_W-1:0] rk_ff, rk_in;
   logic [lsp_pkg::SLOT_W-1:0] rs_ff, rs_in;
   logic                       rok_ff, rok_in, rlast_ff, rlast_in;
   logic [lsp_pkg::LIFE_W-1:0] rl_ff, rl_in;

   logic              fs_we, ls_we, pm_we;
   logic [AW-1:0]     fs_wa, fs_ra, ls_wa, ls_ra, pm_wa, pm_ra;
   logic [AW-1:0]     fs_wd, fs_rd, pm_wd, pm_rd;
   lsp_pkg::entry_type ls_wd, ls_rd_e;
   logic [EW-1:0]     ls_rd;

   logic                       out_free;
   logic [lsp_pkg::CMP_W-1:0]  step_x, life_x;

   lsp_ram #(.DEPTH(lsp_pkg::MAX_SLOTS), .WIDTH(AW)) u_free (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd));

   lsp_ram #(.DEPTH(lsp_pkg::MAX_SLOTS), .WIDTH(EW)) u_list (
      .clock(clock), .wr_en(ls_we), .wr_addr(ls_wa), .wr_data(ls_wd),
      .rd_addr(ls_ra), .rd_data(ls_rd));

   lsp_ram #(.DEPTH(lsp_pkg::MAX_SLOTS), .WIDTH(AW)) u_pos (
      .clock(clock), .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd),
      .rd_addr(pm_ra), .rd_data(pm_rd));

   assign ls_rd_e  = lsp_pkg::entry_type'(ls_rd);
   assign out_free = !rv_ff || !rsp_stall;
   assign step_x   = lsp_pkg::CMP_W'(step_ff);
   assign life_x   = lsp_pkg::CMP_W'(ls_rd_e.life);
   assign cap_sat  = (csr_wdata > lsp_pkg::CAP_W'(lsp_pkg::MAX_SLOTS)) ?
                     lsp_pkg::CAP_W'(lsp_pkg::MAX_SLOTS) : csr_wdata;

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;    cap_in = cap_ff;
      free_in = free_ff;    lcnt_in = lcnt_ff;  idx_in = idx_ff;
      cnt_in = cnt_ff;      init_in = init_ff;  live_in = live_ff;
      step_in = step_ff;    span_in = span_ff;
      pk_in = pk_ff;  ps_in = ps_ff;  pok_in = pok_ff;
      pl_in = pl_ff;  plast_in = plast_ff;
      rv_in = rv_ff && rsp_stall;
      rk_in = rk_ff;  rs_in = rs_ff;  rok_in = rok_ff;
      rl_in = rl_ff;  rlast_in = rlast_ff;
      fs_we = 1'b0;  fs_wa = '0;  fs_wd = '0;  fs_ra = '0;
      ls_we = 1'b0;  ls_wa = '0;  ls_wd = '0;  ls_ra = '0;
      pm_we = 1'b0;  pm_wa = '0;  pm_wd = '0;  pm_ra = '0;

      case (state_ff)
         ST_INIT: begin
            fs_we = 1'b1;
            fs_wa = init_ff[AW-1:0];
            fs_wd = AW'(cap_ff - lsp_pkg::CAP_W'(1) - lsp_pkg::CAP_W'(init_ff));
            init_in = init_ff + CNT_W'(1);
            if (init_ff == CNT_W'(lsp_pkg::MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            step_in = req_time_step;
            span_in = LB'(req_life_span);
            pk_in = lsp_pkg::KIND_SPAWN;  ps_in = '0;  pok_in = 1'b0;
            pl_in = '0;  plast_in = 1'b1;  ret_in = ST_IDLE;
            if (req_valid) begin
               case (req_func)
                  lsp_pkg::FUNC_SPAWN: begin
                     if (free_ff == '0 || lcnt_ff >= CNT_W'(lsp_pkg::MAX_SLOTS)) begin
                        state_in = ST_OUT;
                     end else begin
                        fs_ra    = AW'(free_ff - CNT_W'(1));
                        state_in = ST_SP_RD;
                     end
                  end
                  lsp_pkg::FUNC_TICK: begin
                     idx_in = '0;  cnt_in = lcnt_ff;  state_in = ST_TK_CHK;
                  end
                  lsp_pkg::FUNC_CLEAR: begin
                     idx_in = '0;  state_in = ST_CL_CHK;
                  end
                  default: begin
                     pk_in = lsp_pkg::KIND_QUERY;
                     ps_in = req_query_slot;
                     pm_ra = req_query_slot[AW-1:0];
                     if (req_query_slot < cap_ff &&
                         req_query_slot < lsp_pkg::SLOT_W'(lsp_pkg::MAX_SLOTS) &&
                         live_ff[req_query_slot[AW-1:0]]) begin
                        state_in = ST_Q_RD1;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
               endcase
            end
         end
         ST_SP_RD: begin
            free_in = free_ff - CNT_W'(1);
            pm_we = 1'b1;  pm_wa = fs_rd;  pm_wd = lcnt_ff[AW-1:0];
            live_in[fs_rd] = 1'b1;
            ls_we = 1'b1;  ls_wa = lcnt_ff[AW-1:0];
            ls_wd.slot = fs_rd;  ls_wd.life = span_ff;
            lcnt_in = lcnt_ff + CNT_W'(1);
            ps_in = lsp_pkg::SLOT_W'(fs_rd);  pok_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_TK_CHK: begin
            if (idx_ff >= cnt_ff) begin
               lcnt_in = cnt_ff;
               pk_in = lsp_pkg::KIND_TICK;  ps_in = '0;  pok_in = 1'b0;
               pl_in = '0;  plast_in = 1'b1;
               ret_in = ST_IDLE;  state_in = ST_OUT;
            end else begin
               ls_ra = idx_ff[AW-1:0];
               state_in = ST_TK_RD;
            end
         end
         ST_TK_RD: begin
            if (step_x < life_x) begin
               ls_we = 1'b1;  ls_wa = idx_ff[AW-1:0];
               ls_wd.slot = ls_rd_e.slot;
               ls_wd.life = LB'(life_x - step_x);
               idx_in = idx_ff + CNT_W'(1);
               state_in = ST_TK_CHK;
            end else begin
               live_in[ls_rd_e.slot] = 1'b0;
               fs_we = 1'b1;  fs_wa = free_ff[AW-1:0];  fs_wd = ls_rd_e.slot;
               free_in = free_ff + CNT_W'(1);
               cnt_in = cnt_ff - CNT_W'(1);
               pk_in = lsp_pkg::KIND_RETIRED;
               ps_in = lsp_pkg::SLOT_W'(ls_rd_e.slot);
               pok_in = 1'b0;  pl_in = '0;  plast_in = 1'b0;
               if (idx_ff != cnt_ff - CNT_W'(1)) begin
                  ls_ra = AW'(cnt_ff - CNT_W'(1));
                  state_in = ST_TK_MV;
               end else begin
                  ret_in = ST_TK_CHK;  state_in = ST_OUT;
               end
            end
         end
         ST_TK_MV: begin
            ls_we = 1'b1;  ls_wa = idx_ff[AW-1:0];  ls_wd = ls_rd_e;
            pm_we = 1'b1;  pm_wa = ls_rd_e.slot;  pm_wd = idx_ff[AW-1:0];
            idx_in = idx_ff + CNT_W'(1);
            ret_in = ST_TK_CHK;  state_in = ST_OUT;
         end
         ST_CL_CHK: begin
            if (idx_ff >= lcnt_ff) begin
               lcnt_in = '0;
               pk_in = lsp_pkg::KIND_CLEAR;  ps_in = '0;  pok_in = 1'b0;
               pl_in = '0;  plast_in = 1'b1;
               ret_in = ST_IDLE;  state_in = ST_OUT;
            end else begin
               ls_ra = idx_ff[AW-1:0];
               state_in = ST_CL_RD;
            end
         end
         ST_CL_RD: begin
            live_in[ls_rd_e.slot] = 1'b0;
            fs_we = 1'b1;  fs_wa = free_ff[AW-1:0];  fs_wd = ls_rd_e.slot;
            free_in = free_ff + CNT_W'(1);
            idx_in = idx_ff + CNT_W'(1);
            state_in = ST_CL_CHK;
         end
         ST_Q_RD1: begin
            ls_ra = pm_rd;
            state_in = ST_Q_RD2;
         end
         ST_Q_RD2: begin
            pok_in = 1'b1;
            pl_in = lsp_pkg::LIFE_W'(ls_rd_e.life);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;
               rk_in = pk_ff;  rs_in = ps_ff;  rok_in = pok_ff;
               rl_in = pl_ff;  rlast_in = plast_ff;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         cap_in = cap_sat;
         free_in = CNT_W'(cap_sat);
         lcnt_in = '0;
         live_in = '0;
         init_in = '0;
         state_in = ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff   <= ST_IDLE;
         cap_ff   <= lsp_pkg::CAP_W'(lsp_pkg::MAX_SLOTS);
         free_ff  <= CNT_W'(lsp_pkg::MAX_SLOTS);
         lcnt_ff  <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         init_ff  <= '0;
         live_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cap_ff   <= cap_in;
         free_ff  <= free_in;
         lcnt_ff  <= lcnt_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         init_ff  <= init_in;
         live_ff  <= live_in;
         rv_ff    <= rv_in;
      end
      step_ff  <= step_in;
      span_ff  <= span_in;
      pk_ff    <= pk_in;
      ps_ff    <= ps_in;
      pok_ff   <= pok_in;
      pl_ff    <= pl_in;
      plast_ff <= plast_in;
      rk_ff    <= rk_in;
      rs_ff    <= rs_in;
      rok_ff   <= rok_in;
      rl_ff    <= rl_in;
      rlast_ff <= rlast_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rv_ff;
   assign rsp_kind      = rk_ff;
   assign rsp_slot      = rs_ff;
   assign rsp_ok        = rok_ff;
   assign rsp_life_left = rl_ff;
   assign rsp_last      = rlast_ff;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lifetime_slot_pool (spawn, tick, clear, query)
// depends on lsp_pkg and the lifetime_slot_pool rtl; a local pool model predicts results
module testbench;

   localparam int MAX_SLOTS = lsp_pkg::MAX_SLOTS;
   localparam int FUNC_W    = lsp_pkg::FUNC_W;
   localparam int LIFE_W    = lsp_pkg::LIFE_W;
   localparam int SLOT_W    = lsp_pkg::SLOT_W;
   localparam int KIND_W    = lsp_pkg::KIND_W;
   localparam int CAP_W     = lsp_pkg::CAP_W;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LIFE_W-1:0] span;
      logic [LIFE_W-1:0] step;
      logic [SLOT_W-1:0] qslot;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              ok;
      logic [LIFE_W-1:0] life;
      logic              last;
   } rsp_item_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [LIFE_W-1:0] req_life_span = '0;
   logic [LIFE_W-1:0] req_time_step = '0;
   logic [SLOT_W-1:0] req_query_slot = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [KIND_W-1:0] rsp_kind;
   logic [SLOT_W-1:0] rsp_slot;
   logic rsp_ok;
   logic [LIFE_W-1:0] rsp_life_left;
   logic rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_wdata = '0;

   lifetime_slot_pool uut (.*);

   always #4 clock = ~clock;

   // pool model
   int unsigned pool_cap;
   logic [4:0]  free_slots[MAX_SLOTS];
   int unsigned free_num;
   logic [4:0]  list_slot[MAX_SLOTS];
   logic [LIFE_W-1:0] list_life[MAX_SLOTS];
   logic [5:0]  slot_pos[MAX_SLOTS];
   bit          slot_alive[MAX_SLOTS];
   int unsigned alive_num;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int mismatches = 0;
   int sender_idle = 19, receiver_idle = 63;
   int quiet_cycles = 0;

   task automatic add_req(input req_item_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic add_rsp(input rsp_item_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   task automatic pool_restart(input int unsigned cap);
      pool_cap = (cap > MAX_SLOTS) ? MAX_SLOTS : cap;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_alive[i] = 0;
         free_slots[i] = '0;
      end
      for (int i = 0; i < pool_cap; i++) free_slots[i] = 5'(pool_cap - 1 - i);
      free_num = pool_cap;
      alive_num = 0;
   endtask

   function automatic rsp_item_type mk(input logic [KIND_W-1:0] k, input int s,
                                       input bit o, input logic [LIFE_W-1:0] l,
                                       input bit lst);
      rsp_item_type r;
      r.kind = k; r.slot = 6'(s); r.ok = o; r.life = l; r.last = lst;
      return r;
   endfunction

   task automatic pool_apply(input req_item_type it);
      int unsigned cnt;
      int unsigned i;
      logic [4:0] s;
      case (it.func)
         lsp_pkg::FUNC_SPAWN: begin
            if (free_num == 0 || alive_num >= MAX_SLOTS) begin
               add_rsp(mk(lsp_pkg::KIND_SPAWN, 0, 0, 0, 1));
            end else begin
               free_num--;
               s = free_slots[free_num];
               slot_pos[s] = 6'(alive_num);
               slot_alive[s] = 1;
               list_slot[alive_num] = s;
               list_life[alive_num] = it.span;
               alive_num++;
               add_rsp(mk(lsp_pkg::KIND_SPAWN, s, 1, 0, 1));
            end
         end
         lsp_pkg::FUNC_TICK: begin
            cnt = alive_num;
            i = 0;
            while (i < cnt) begin
               if (it.step < list_life[i]) begin
                  list_life[i] -= it.step;
               end else begin
                  s = list_slot[i];
                  if (i != cnt - 1) begin
                     list_slot[i] = list_slot[cnt-1];
                     list_life[i] = list_life[cnt-1];
                     slot_pos[list_slot[i]] = 6'(i);
                     list_slot[cnt-1] = s;
                  end
                  slot_alive[s] = 0;
                  if (free_num < MAX_SLOTS) begin
                     free_slots[free_num] = s;
                     free_num++;
                  end
                  cnt--;
                  add_rsp(mk(lsp_pkg::KIND_RETIRED, s, 0, 0, 0));
               end
               i++;
            end
            alive_num = cnt;
            add_rsp(mk(lsp_pkg::KIND_TICK, 0, 0, 0, 1));
         end
         lsp_pkg::FUNC_CLEAR: begin
            for (i = 0; i < alive_num; i++) begin
               slot_alive[list_slot[i]] = 0;
               if (free_num < MAX_SLOTS) begin
                  free_slots[free_num] = list_slot[i];
                  free_num++;
               end
            end
            alive_num = 0;
            add_rsp(mk(lsp_pkg::KIND_CLEAR, 0, 0, 0, 1));
         end
         default: begin
            if (it.qslot < pool_cap && slot_alive[it.qslot[4:0]])
               add_rsp(mk(lsp_pkg::KIND_QUERY, it.qslot, 1,
                          list_life[slot_pos[it.qslot[4:0]]], 1));
            else
               add_rsp(mk(lsp_pkg::KIND_QUERY, it.qslot, 0, 0, 1));
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pool_apply({req_func, req_life_span, req_time_step, req_query_slot});
            void'(pending_reqs.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle) begin
               req_valid <= 1;
               {req_func, req_life_span, req_time_step, req_query_slot} <=
                  pending_reqs[0];
            end else begin
               req_valid <= 0;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_slot, rsp_ok, rsp_life_left, rsp_last};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: kind %0d/%0d slot %0d/%0d ok %0b/%0b",
                               " life %h/%h last %0b/%0b"},
                              want.kind, got.kind, want.slot, got.slot, want.ok, got.ok,
                              want.life, got.life, want.last, got.last);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic req_item_type rnd_req(input int cap);
      req_item_type r;
      int p;
      p = $urandom_range(99);
      r.func = (p < 45) ? lsp_pkg::FUNC_SPAWN :
               (p < 70) ? lsp_pkg::FUNC_TICK :
               (p < 75) ? lsp_pkg::FUNC_CLEAR : lsp_pkg::FUNC_QUERY;
      r.span = ($urandom_range(3) == 0) ? LIFE_W'($urandom) : LIFE_W'($urandom_range(400000));
      r.step = ($urandom_range(7) == 0) ? LIFE_W'($urandom) : LIFE_W'($urandom_range(120000));
      r.qslot = ($urandom_range(4) == 0) ? SLOT_W'($urandom) :
                SLOT_W'($urandom_range(cap > 0 ? cap - 1 : 0));
      return r;
   endfunction

   function automatic req_item_type mkreq(input logic [FUNC_W-1:0] f, input int unsigned sp,
                                          input int unsigned st, input int q);
      req_item_type r;
      r.func = f; r.span = LIFE_W'(sp); r.step = LIFE_W'(st); r.qslot = SLOT_W'(q);
      return r;
   endfunction

   task automatic drain();
      while (!(pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0))
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      pool_restart(int'(v));
   endtask

   initial begin
      logic [CAP_W-1:0] caps[4] = '{6'd2, 6'd0, 6'd63, 6'd9};
      pool_restart(MAX_SLOTS);
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 24'hFFFFFF, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 0, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 5, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 3, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 1, 0, 1));
      add_req(mkreq(lsp_pkg::FUNC_TICK, 0, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 2));
      add_req(mkreq(lsp_pkg::FUNC_TICK, 0, 3, 0));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 3));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 63));
      add_req(mkreq(lsp_pkg::FUNC_TICK, 0, 24'hFFFFFF, 0));
      add_req(mkreq(lsp_pkg::FUNC_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 63));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 24'hAAAAAA, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_SPAWN, 24'h555555, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_CLEAR, 0, 0, 0));
      drain();
      // full pool then spawn failure
      write_capacity(6'd2);
      for (int i = 0; i < 3; i++) add_req(mkreq(lsp_pkg::FUNC_SPAWN, 100, 0, 0));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 1));
      add_req(mkreq(lsp_pkg::FUNC_QUERY, 0, 0, 2));
      add_req(mkreq(lsp_pkg::FUNC_TICK, 0, 100, 0));
      drain();
      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin sender_idle = 63; receiver_idle = 19; end
         if (ph == 4) begin sender_idle = 0; receiver_idle = 0; end
         write_capacity((ph < 4) ? caps[ph] : (ph == 4 ? 6'd32 : 6'd1));
         for (int i = 0; i < 60; i++) add_req(rnd_req(int'(pool_cap)));
         drain();
      end
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/lsp_pkg.sv
rtl/lsp_ram.sv
rtl/lifetime_slot_pool.sv
bench/testbench.sv
